/* sv/rcdn_pkg.sv */
// ----------------------------------------------------------------------------
// rcdn_pkg: shared types and constants of the RC channel normalizer
// Frame and result layouts, calibration register map, per-axis job records
// and the helper functions used by the classifier and the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rcdn_pkg;

  localparam int RAW_W       = 16;
  localparam int FRAC_W      = 15;
  localparam int AXIS_W      = FRAC_W + 1;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 3;
  localparam int ADDR_W      = REG_IDX_W + 2;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [RAW_W-1:0]  TELEOP_THRESHOLD = RAW_W'(1500);
  localparam logic [AXIS_W-1:0] AXIS_FULL        = {1'b0, {FRAC_W{1'b1}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STEER_MIN          = 3'd0,
    REG_STEER_MAX          = 3'd1,
    REG_STEER_DEAD_LOW     = 3'd2,
    REG_STEER_DEAD_HIGH    = 3'd3,
    REG_THROTTLE_MIN       = 3'd4,
    REG_THROTTLE_MAX       = 3'd5,
    REG_THROTTLE_DEAD_LOW  = 3'd6,
    REG_THROTTLE_DEAD_HIGH = 3'd7
  } reg_idx_t;

  localparam logic [RAW_W-1:0] REG_RESET [NUM_REGS] = '{
    RAW_W'(1038), RAW_W'(1990), RAW_W'(1493), RAW_W'(1504),
    RAW_W'(1013), RAW_W'(1940), RAW_W'(1492), RAW_W'(1504)
  };

  typedef struct packed {
    logic [RAW_W-1:0] steer_raw;
    logic [RAW_W-1:0] throttle_raw;
    logic [RAW_W-1:0] teleop_raw;
  } in_item_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] steer_axis;
    logic signed [AXIS_W-1:0] throttle_axis;
    logic                     teleop_button;
  } out_item_t;

  typedef struct packed {
    logic [RAW_W-1:0] vmin;
    logic [RAW_W-1:0] vmax;
    logic [RAW_W-1:0] dlow;
    logic [RAW_W-1:0] dhigh;
  } cal_t;

  typedef enum logic [1:0] {
    AX_ZERO = 2'd0,
    AX_FULL = 2'd1,
    AX_DIV  = 2'd2
  } ax_kind_t;

  typedef struct packed {
    ax_kind_t         kind;
    logic             neg;
    logic [RAW_W-1:0] num;
    logic [RAW_W-1:0] den;
  } ax_job_t;

  typedef struct packed {
    logic    teleop;
    ax_job_t steer;
    ax_job_t throttle;
  } job_t;

  // One axis in flight through the divider. acc holds the dividend bits not
  // yet consumed in its upper part and the quotient bits found so far below.
  typedef struct packed {
    ax_kind_t          kind;
    logic              neg;
    logic [RAW_W-1:0]  den;
    logic [RAW_W-1:0]  rem;
    logic [FRAC_W-1:0] acc;
  } ax_div_t;

  typedef struct packed {
    logic    teleop;
    ax_div_t steer;
    ax_div_t throttle;
  } div_item_t;

  // Dead band test and selection of numerator and denominator. When the
  // numerator reaches the denominator the scaled quotient is at or above
  // full scale, so it is settled here as a saturated result.
  function automatic ax_job_t classify(input logic [RAW_W-1:0] raw, input cal_t cal);
    ax_job_t j;
    j.kind = AX_ZERO;
    j.neg  = 1'b0;
    j.num  = '0;
    j.den  = '0;
    if (raw >= cal.dlow && raw <= cal.dhigh) begin
      j.kind = AX_ZERO;
    end else if (raw > cal.dhigh) begin
      j.num = raw - cal.dhigh;
      j.den = cal.vmax - cal.dhigh;
      if (cal.vmax <= cal.dhigh || j.num >= j.den) begin
        j.kind = AX_FULL;
      end else begin
        j.kind = AX_DIV;
      end
    end else begin
      j.neg = 1'b1;
      j.num = cal.dlow - raw;
      j.den = cal.dlow - cal.vmin;
      if (cal.dlow <= cal.vmin || j.num >= j.den) begin
        j.kind = AX_FULL;
      end else begin
        j.kind = AX_DIV;
      end
    end
    return j;
  endfunction

  // Forms num * AXIS_FULL as a shift and subtract and loads the divider.
  function automatic ax_div_t div_start(input ax_job_t j);
    ax_div_t d;
    logic [RAW_W+FRAC_W-1:0] prod;
    prod   = {j.num, {FRAC_W{1'b0}}} - {{FRAC_W{1'b0}}, j.num};
    d.kind = j.kind;
    d.neg  = j.neg;
    d.den  = j.den;
    d.rem  = prod[RAW_W+FRAC_W-1:FRAC_W];
    d.acc  = prod[FRAC_W-1:0];
    return d;
  endfunction

  // One restoring division step: one quotient bit.
  function automatic ax_div_t div_step(input ax_div_t d);
    ax_div_t  n;
    logic [RAW_W:0] trial;
    logic [RAW_W:0] diff;
    logic           qbit;
    n     = d;
    trial = {d.rem, d.acc[FRAC_W-1]};
    diff  = trial - {1'b0, d.den};
    qbit  = (trial >= {1'b0, d.den});
    n.rem = qbit ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
    n.acc = {d.acc[FRAC_W-2:0], qbit};
    return n;
  endfunction

  function automatic logic [AXIS_W-1:0] axis_value(input ax_div_t d);
    logic [AXIS_W-1:0] mag;
    case (d.kind)
      AX_ZERO: mag = '0;
      AX_FULL: mag = AXIS_FULL;
      AX_DIV:  mag = {1'b0, d.acc};
      default: mag = '0;
    endcase
    return d.neg ? (AXIS_W'(0) - mag) : mag;
  endfunction

endpackage

`default_nettype wire

/* sv/rcdn_regs.sv */
// ----------------------------------------------------------------------------
// rcdn_regs: calibration register file
// APB-style write and read access to the eight 16-bit calibration registers,
// presented as one calibration record per axis.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdn_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rcdn_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rcdn_pkg::DATA_W-1:0]   pwdata,
  output logic      [rcdn_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output rcdn_pkg::cal_t                     steer_cal,
  output rcdn_pkg::cal_t                     throttle_cal
);

  logic [rcdn_pkg::RAW_W-1:0] regs_r   [rcdn_pkg::NUM_REGS];
  logic [rcdn_pkg::RAW_W-1:0] regs_nxt [rcdn_pkg::NUM_REGS];
  logic [rcdn_pkg::REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[rcdn_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = {{(rcdn_pkg::DATA_W-rcdn_pkg::RAW_W){1'b0}}, regs_r[idx]};

  always_comb begin
    for (int i = 0; i < rcdn_pkg::NUM_REGS; i++) begin
      regs_nxt[i] = regs_r[i];
    end
    if (wr_en) begin
      regs_nxt[idx] = pwdata[rcdn_pkg::RAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rcdn_pkg::NUM_REGS; i++) begin
        regs_r[i] <= rcdn_pkg::REG_RESET[i];
      end
    end else begin
      for (int i = 0; i < rcdn_pkg::NUM_REGS; i++) begin
        regs_r[i] <= regs_nxt[i];
      end
    end
  end

  assign steer_cal.vmin     = regs_r[rcdn_pkg::REG_STEER_MIN];
  assign steer_cal.vmax     = regs_r[rcdn_pkg::REG_STEER_MAX];
  assign steer_cal.dlow     = regs_r[rcdn_pkg::REG_STEER_DEAD_LOW];
  assign steer_cal.dhigh    = regs_r[rcdn_pkg::REG_STEER_DEAD_HIGH];
  assign throttle_cal.vmin  = regs_r[rcdn_pkg::REG_THROTTLE_MIN];
  assign throttle_cal.vmax  = regs_r[rcdn_pkg::REG_THROTTLE_MAX];
  assign throttle_cal.dlow  = regs_r[rcdn_pkg::REG_THROTTLE_DEAD_LOW];
  assign throttle_cal.dhigh = regs_r[rcdn_pkg::REG_THROTTLE_DEAD_HIGH];

endmodule

`default_nettype wire

/* sv/rcdn_front.sv */
// ----------------------------------------------------------------------------
// rcdn_front: frame classifier
// Sorts each axis of an incoming frame into dead band, saturated or divide,
// prepares numerator and denominator, and decodes the teleop button.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdn_front (
  input  wire rcdn_pkg::in_item_t frame,
  input  wire rcdn_pkg::cal_t     steer_cal,
  input  wire rcdn_pkg::cal_t     throttle_cal,
  output rcdn_pkg::job_t          job
);

  always_comb begin
    job.teleop   = (frame.teleop_raw > rcdn_pkg::TELEOP_THRESHOLD);
    job.steer    = rcdn_pkg::classify(frame.steer_raw, steer_cal);
    job.throttle = rcdn_pkg::classify(frame.throttle_raw, throttle_cal);
  end

endmodule

`default_nettype wire

/* sv/rcdn_queue.sv */
// ----------------------------------------------------------------------------
// rcdn_queue: job queue between classifier and divider
// A two-entry flip-flop FIFO so that the input side and the divider pipeline
// can stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdn_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire rcdn_pkg::job_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output rcdn_pkg::job_t      head
);

  rcdn_pkg::job_t              mem_r [rcdn_pkg::QUEUE_DEPTH];
  logic [rcdn_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rcdn_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rcdn_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == rcdn_pkg::QCNT_W'(rcdn_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* sv/rcdn_back.sv */
// ----------------------------------------------------------------------------
// rcdn_back: divider pipeline and result register
// A load stage forms the scaled dividend, then one restoring division stage
// per quotient bit for both axes side by side, then the signed result
// register. The whole pipeline holds while a finished result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdn_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  input  wire rcdn_pkg::job_t job,
  output logic                job_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rcdn_pkg::out_item_t out_data
);

  localparam int NSTG = rcdn_pkg::FRAC_W + 1;

  rcdn_pkg::div_item_t stage_r   [NSTG];
  rcdn_pkg::div_item_t stage_nxt [NSTG];
  logic [NSTG-1:0]     valid_r;
  logic [NSTG-1:0]     valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  rcdn_pkg::out_item_t out_data_r, out_data_nxt;
  logic                adv;

  assign adv       = !(out_valid_r && out_stall);
  assign job_pop   = adv && job_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stage_nxt[0].teleop   = job.teleop;
    stage_nxt[0].steer    = rcdn_pkg::div_start(job.steer);
    stage_nxt[0].throttle = rcdn_pkg::div_start(job.throttle);
    valid_nxt[0]          = job_valid;
    for (int i = 1; i < NSTG; i++) begin
      stage_nxt[i].teleop   = stage_r[i-1].teleop;
      stage_nxt[i].steer    = rcdn_pkg::div_step(stage_r[i-1].steer);
      stage_nxt[i].throttle = rcdn_pkg::div_step(stage_r[i-1].throttle);
      valid_nxt[i]          = valid_r[i-1];
    end
    out_valid_nxt              = valid_r[NSTG-1];
    out_data_nxt.teleop_button = stage_r[NSTG-1].teleop;
    out_data_nxt.steer_axis    = rcdn_pkg::axis_value(stage_r[NSTG-1].steer);
    out_data_nxt.throttle_axis = rcdn_pkg::axis_value(stage_r[NSTG-1].throttle);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NSTG; i++) begin
        stage_r[i] <= stage_nxt[i];
      end
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/rc_channel_deadband_normalizer.sv */
// ----------------------------------------------------------------------------
// rc_channel_deadband_normalizer: RC stick dead band normalizer
// Turns raw steering and throttle pulse values into signed Q1.15 axes and
// decodes the teleop switch.
//
// Each request on the in_ channel is one receiver frame; it produces exactly
// one request on the out_ channel, in order. Calibration registers are
// written over the APB-style port; the user must do so only while no frame is
// in flight, which the block itself does not enforce. An accepted frame is
// written into the two-entry job queue, the load stage takes it from there,
// then fifteen divider stages (one quotient bit each, both axes in parallel)
// and the result register follow. The fully pipelined divider takes one frame
// per cycle while out_stall does not hold a result. in_stall rises only when
// the job queue is full. When out_stall holds a result, the divider pipeline
// freezes; the queue then fills to its two entries and in_stall is asserted.
// Reset empties the queue and pipeline and returns every calibration register
// to its default value.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_channel_deadband_normalizer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rcdn_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rcdn_pkg::out_item_t              out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rcdn_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rcdn_pkg::DATA_W-1:0] pwdata,
  output logic      [rcdn_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  rcdn_pkg::cal_t steer_cal;
  rcdn_pkg::cal_t throttle_cal;
  rcdn_pkg::job_t front_job;
  rcdn_pkg::job_t queue_head;
  logic           queue_full;
  logic           queue_not_empty;
  logic           queue_pop;
  logic           queue_push;

  assign in_stall   = queue_full;
  assign queue_push = in_valid && !queue_full;

  rcdn_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .steer_cal    (steer_cal),
    .throttle_cal (throttle_cal)
  );

  rcdn_front u_front (
    .frame        (in_data),
    .steer_cal    (steer_cal),
    .throttle_cal (throttle_cal),
    .job          (front_job)
  );

  rcdn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (queue_push),
    .push_data (front_job),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_not_empty),
    .head      (queue_head)
  );

  rcdn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (queue_not_empty),
    .job       (queue_head),
    .job_pop   (queue_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* verif/rc_channel_deadband_normalizer_test.sv */
// ----------------------------------------------------------------------------
// rc_channel_deadband_normalizer_test: self-checking bench for the normalizer
// Programs the calibration registers over the APB-style port, streams receiver
// frames with random gaps and back-pressure, and checks every result against
// an in-bench prediction of the dead band and scaling rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rc_channel_deadband_normalizer_test;

  localparam int IDLE_PCT     = 31;
  localparam int PHASE_FRAMES = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAW_W        = rcdn_pkg::RAW_W;
  localparam int AXIS_W       = rcdn_pkg::AXIS_W;
  localparam int DATA_W       = rcdn_pkg::DATA_W;
  localparam int JUNK_W       = DATA_W - RAW_W;

  typedef enum int {
    CAL_TYPICAL,
    CAL_RANDOM,
    CAL_ZERO,
    CAL_TOP,
    CAL_NARROW,
    CAL_WIDE,
    CAL_INVERTED
  } cal_kind_t;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  rcdn_pkg::in_item_t          in_data   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  rcdn_pkg::out_item_t         out_data;
  logic                        psel      = 1'b0;
  logic                        penable   = 1'b0;
  logic                        pwrite    = 1'b0;
  logic [rcdn_pkg::ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0]           pwdata    = '0;
  logic [DATA_W-1:0]           prdata;
  logic                        pready;

  logic [RAW_W-1:0]    cal_regs [rcdn_pkg::NUM_REGS];
  rcdn_pkg::in_item_t  frame_queue[$];
  rcdn_pkg::out_item_t predicted_axes[$];
  logic                in_taken  = 1'b0;
  logic                calm      = 1'b0;
  int                  errors    = 0;
  int                  frames_checked = 0;
  int                  settings_used  = 1;
  int                  saturated_cnt  = 0;
  int                  deadband_cnt   = 0;
  int                  fraction_cnt   = 0;

  rc_channel_deadband_normalizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scaled and clamped axis for one channel, as a 16-bit two's complement value.
  function automatic logic [AXIS_W-1:0] axis_predict(input logic [RAW_W-1:0] raw,
                                                     input logic [RAW_W-1:0] vmin,
                                                     input logic [RAW_W-1:0] vmax,
                                                     input logic [RAW_W-1:0] dlow,
                                                     input logic [RAW_W-1:0] dhigh);
    longint unsigned full;
    longint unsigned mag;
    full = longint'(rcdn_pkg::AXIS_FULL);
    if (raw >= dlow && raw <= dhigh) return '0;
    if (raw > dhigh) begin
      if (vmax <= dhigh) return rcdn_pkg::AXIS_FULL;
      mag = ((longint'(raw) - longint'(dhigh)) * full) /
            (longint'(vmax) - longint'(dhigh));
      if (mag > full) mag = full;
      return mag[AXIS_W-1:0];
    end
    // Below the band, which also covers an inverted band.
    if (dlow <= vmin) begin
      mag = full;
    end else begin
      mag = ((longint'(dlow) - longint'(raw)) * full) /
            (longint'(dlow) - longint'(vmin));
      if (mag > full) mag = full;
    end
    return AXIS_W'(0) - mag[AXIS_W-1:0];
  endfunction

  function automatic rcdn_pkg::out_item_t normalize_frame(input rcdn_pkg::in_item_t f);
    rcdn_pkg::out_item_t r;
    r.steer_axis    = axis_predict(f.steer_raw,
                                   cal_regs[rcdn_pkg::REG_STEER_MIN],
                                   cal_regs[rcdn_pkg::REG_STEER_MAX],
                                   cal_regs[rcdn_pkg::REG_STEER_DEAD_LOW],
                                   cal_regs[rcdn_pkg::REG_STEER_DEAD_HIGH]);
    r.throttle_axis = axis_predict(f.throttle_raw,
                                   cal_regs[rcdn_pkg::REG_THROTTLE_MIN],
                                   cal_regs[rcdn_pkg::REG_THROTTLE_MAX],
                                   cal_regs[rcdn_pkg::REG_THROTTLE_DEAD_LOW],
                                   cal_regs[rcdn_pkg::REG_THROTTLE_DEAD_HIGH]);
    r.teleop_button = (f.teleop_raw > rcdn_pkg::TELEOP_THRESHOLD);
    return r;
  endfunction

  // Raw values cluster around the calibration points, with uniform noise mixed in.
  function automatic logic [RAW_W-1:0] pick_raw(input int base);
    logic [RAW_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        v = cal_regs[base + int'($urandom_range(3))];
        v = v + RAW_W'($urandom_range(40)) - RAW_W'(20);
      end
      4, 5, 6: v = RAW_W'($urandom);
      default: v = RAW_W'($urandom_range(cal_regs[base], cal_regs[base + 1]));
    endcase
    return v;
  endfunction

  function automatic logic [RAW_W-1:0] pick_teleop();
    if ($urandom_range(1)) return RAW_W'($urandom_range(1510, 1490));
    return RAW_W'($urandom);
  endfunction

  task automatic queue_frame(input logic [RAW_W-1:0] s, input logic [RAW_W-1:0] t,
                             input logic [RAW_W-1:0] p);
    rcdn_pkg::in_item_t f;
    f.steer_raw    = s;
    f.throttle_raw = t;
    f.teleop_raw   = p;
    frame_queue.insert(frame_queue.size(), f);
  endtask

  // Upper data bits carry junk; the register keeps only its low 16 bits.
  task automatic cfg_write(input rcdn_pkg::reg_idx_t idx, input logic [RAW_W-1:0] value);
    logic [JUNK_W-1:0] junk;
    junk = JUNK_W'($urandom);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cal_regs[idx] = value;
  endtask

  task automatic program_axis(input int base, input cal_kind_t kind);
    logic [RAW_W-1:0] vmin, vmax, dlow, dhigh, c;
    case (kind)
      CAL_TYPICAL: begin
        c     = RAW_W'($urandom_range(1700, 1300));
        dlow  = c - RAW_W'($urandom_range(30));
        dhigh = c + RAW_W'($urandom_range(30));
        vmin  = dlow - RAW_W'($urandom_range(600, 1));
        vmax  = dhigh + RAW_W'($urandom_range(600, 1));
      end
      CAL_ZERO: begin
        vmin = '0; vmax = '0; dlow = '0; dhigh = '0;
      end
      CAL_TOP: begin
        vmin = '1; vmax = '1; dlow = '1; dhigh = '1;
      end
      CAL_NARROW: begin
        c     = RAW_W'($urandom_range(65530, 5));
        dlow  = c;
        vmin  = c - RAW_W'($urandom_range(2, 1));
        dhigh = c + RAW_W'($urandom_range(1));
        vmax  = dhigh + RAW_W'($urandom_range(2, 1));
      end
      CAL_WIDE: begin
        vmin  = '0;
        vmax  = '1;
        dlow  = RAW_W'($urandom);
        dhigh = dlow;
      end
      CAL_INVERTED: begin
        dhigh = RAW_W'($urandom_range(30000));
        dlow  = dhigh + RAW_W'($urandom_range(1000, 1));
        vmin  = RAW_W'($urandom);
        vmax  = RAW_W'($urandom);
      end
      default: begin
        vmin  = RAW_W'($urandom);
        vmax  = RAW_W'($urandom);
        dlow  = RAW_W'($urandom);
        dhigh = RAW_W'($urandom);
      end
    endcase
    cfg_write(rcdn_pkg::reg_idx_t'(base),     vmin);
    cfg_write(rcdn_pkg::reg_idx_t'(base + 1), vmax);
    cfg_write(rcdn_pkg::reg_idx_t'(base + 2), dlow);
    cfg_write(rcdn_pkg::reg_idx_t'(base + 3), dhigh);
  endtask

  // The sender is held off here until every predicted result has come back.
  task automatic drain();
    while (frame_queue.size() != 0 || in_valid || predicted_axes.size() != 0)
      @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    if (!in_valid || in_taken) begin
      if (frame_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= frame_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    rcdn_pkg::out_item_t want;
    logic signed [AXIS_W-1:0] ax [2];
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall)
        predicted_axes.insert(predicted_axes.size(), normalize_frame(in_data));
      if (out_valid && !out_stall) begin
        if (predicted_axes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result request: steer %0d throttle %0d teleop %0b",
                   $time, out_data.steer_axis, out_data.throttle_axis,
                   out_data.teleop_button);
        end else begin
          want = predicted_axes.pop_front();
          frames_checked++;
          if (out_data.steer_axis !== want.steer_axis ||
              out_data.throttle_axis !== want.throttle_axis ||
              out_data.teleop_button !== want.teleop_button) begin
            errors++;
            $display("%0t: mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                     $time, want.steer_axis, want.throttle_axis, want.teleop_button,
                     out_data.steer_axis, out_data.throttle_axis, out_data.teleop_button);
          end
          ax[0] = want.steer_axis;
          ax[1] = want.throttle_axis;
          for (int k = 0; k < 2; k++) begin
            if (ax[k] == 0) deadband_cnt++;
            else if (ax[k] == $signed(rcdn_pkg::AXIS_FULL) ||
                     ax[k] == -$signed(rcdn_pkg::AXIS_FULL))
              saturated_cnt++;
            else fraction_cnt++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    cal_kind_t kinds [8];
    kinds = '{CAL_TYPICAL, CAL_RANDOM, CAL_ZERO, CAL_TOP,
              CAL_NARROW, CAL_WIDE, CAL_INVERTED, CAL_TYPICAL};
    for (int i = 0; i < rcdn_pkg::NUM_REGS; i++) cal_regs[i] = rcdn_pkg::REG_RESET[i];
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset calibration: band edges, range ends, values past them, field extremes.
    queue_frame(16'd0,     16'd0,     16'd0);
    queue_frame(16'hFFFF,  16'hFFFF,  16'hFFFF);
    queue_frame(16'd1493,  16'd1492,  16'd1500);
    queue_frame(16'd1504,  16'd1504,  16'd1501);
    queue_frame(16'd1492,  16'd1491,  16'd1499);
    queue_frame(16'd1505,  16'd1505,  16'd1502);
    queue_frame(16'd1038,  16'd1013,  16'd0);
    queue_frame(16'd1990,  16'd1940,  16'hFFFF);
    queue_frame(16'd1037,  16'd1012,  16'd1);
    queue_frame(16'd1991,  16'd1941,  16'h8000);
    queue_frame(16'd1700,  16'd1300,  16'd1500);
    queue_frame(16'd1200,  16'd1800,  16'd1501);
    drain();

    // Empty range above the steering band and below the throttle band.
    cfg_write(rcdn_pkg::REG_STEER_MAX, 16'd1504);
    cfg_write(rcdn_pkg::REG_THROTTLE_DEAD_LOW, 16'd1013);
    settings_used++;
    queue_frame(16'd1505,  16'd1012,  16'd0);
    queue_frame(16'hFFFF,  16'd0,     16'hFFFF);
    queue_frame(16'd1504,  16'd1013,  16'd1500);
    queue_frame(16'd1400,  16'd1600,  16'd1501);
    drain();

    // Inverted dead band on both channels.
    cfg_write(rcdn_pkg::REG_STEER_MAX, 16'd1990);
    cfg_write(rcdn_pkg::REG_STEER_DEAD_LOW, 16'd1600);
    cfg_write(rcdn_pkg::REG_STEER_DEAD_HIGH, 16'd1400);
    cfg_write(rcdn_pkg::REG_THROTTLE_DEAD_LOW, 16'd1600);
    cfg_write(rcdn_pkg::REG_THROTTLE_DEAD_HIGH, 16'd1400);
    settings_used++;
    queue_frame(16'd1500,  16'd1500,  16'd1499);
    queue_frame(16'd1400,  16'd1401,  16'd1501);
    queue_frame(16'd1401,  16'd1400,  16'd0);
    queue_frame(16'd1600,  16'd1599,  16'hFFFF);
    queue_frame(16'd0,     16'hFFFF,  16'd1500);
    drain();

    for (int p = 0; p < 8; p++) begin
      program_axis(rcdn_pkg::REG_STEER_MIN, kinds[p]);
      program_axis(rcdn_pkg::REG_THROTTLE_MIN, kinds[(p + 3) % 8]);
      settings_used++;
      calm = (p == 4);
      for (int n = 0; n < PHASE_FRAMES; n++)
        queue_frame(pick_raw(rcdn_pkg::REG_STEER_MIN), pick_raw(rcdn_pkg::REG_THROTTLE_MIN),
                    pick_teleop());
      drain();
      calm = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d frames across %0d calibration settings.",
             frames_checked, settings_used);
    $display("Axis outcomes: %0d saturated, %0d in the dead band, %0d fractional.",
             saturated_cnt, deadband_cnt, fraction_cnt);
    if (errors == 0 && predicted_axes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
